FILE: rtl/core/fcst_pkg.sv
`default_nettype none

package fcst_pkg;

  localparam int CAPACITY    = 32;
  localparam int VALUE_WIDTH = 32;

  // slot index and entry count widths (count must reach CAPACITY itself)
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;
  localparam logic [1:0] REQ_READ   = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] value;
    logic [4:0]  index;
  } fcst_in_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] read_value;
    logic [5:0]  entry_count;
  } fcst_out_t;

endpackage

`default_nettype wire

FILE: rtl/core/fcst_ram.sv
`default_nettype none

module fcst_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/fixed_capacity_set_table_unit.sv
`default_nettype none

// Channel  Signals                         Dir  Transfer when
// in       in_valid, in_ready, in_data     in   in_valid & in_ready
// out      out_valid, out_ready, out_data  out  out_valid & out_ready
//
// One request at a time. Insert, query and remove scan linearly, one entry RAM
// read per cycle, up to the hit or past the last entry; a remove that hits then
// runs the compaction shift, one read and one write per cycle; read by index
// reads its one slot, and fails when the index is not below the count.
// Synchronous reset empties the set; entries need no clearing.
// The result sits in an output register, so a stalled out channel blocks only
// the completion of the following request.
module fixed_capacity_set_table_unit
  import fcst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire fcst_in_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output fcst_out_t      out_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_RDWAIT,
    ST_FIN
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             req_r, req_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       scan_r, scan_nxt;
  logic                   pend_r, pend_nxt;
  logic [IDX_W-1:0]       pend_idx_r, pend_idx_nxt;
  logic                   res_ok_r, res_ok_nxt;
  logic [31:0]            res_rd_r, res_rd_nxt;
  logic                   out_valid_r, out_valid_nxt;
  fcst_out_t              out_r, out_nxt;

  logic                   mem_we;
  logic [IDX_W-1:0]       mem_wa;
  logic [VALUE_WIDTH-1:0] mem_wd;
  logic                   mem_re;
  logic [IDX_W-1:0]       mem_ra;
  logic [VALUE_WIDTH-1:0] mem_rdata;
  logic                   hit;

  fcst_ram #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .re    (mem_re),
    .raddr (mem_ra),
    .rdata (mem_rdata)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign hit = pend_r && (mem_rdata == value_r);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    value_nxt     = value_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    pend_nxt      = pend_r;
    pend_idx_nxt  = pend_idx_r;
    res_ok_nxt    = res_ok_r;
    res_rd_nxt    = res_rd_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    mem_we        = 1'b0;
    mem_wa        = '0;
    mem_wd        = '0;
    mem_re        = 1'b0;
    mem_ra        = '0;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          req_nxt    = in_data.req_type;
          value_nxt  = VALUE_WIDTH'(in_data.value);
          scan_nxt   = '0;
          pend_nxt   = 1'b0;
          res_ok_nxt = 1'b0;
          res_rd_nxt = '0;
          if (in_data.req_type == REQ_READ) begin
            if (CNT_W'(in_data.index) < count_r) begin
              mem_re    = 1'b1;
              mem_ra    = IDX_W'(in_data.index);
              state_nxt = ST_RDWAIT;
            end else begin
              state_nxt = ST_FIN;
            end
          end else begin
            state_nxt = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // compare the entry read last cycle while the next one is fetched
        if (hit) begin
          case (req_r)
            REQ_INSERT: begin
              state_nxt = ST_FIN;
            end
            REQ_REMOVE: begin
              res_ok_nxt = 1'b1;
              scan_nxt   = CNT_W'(pend_idx_r) + CNT_W'(1);
              pend_nxt   = 1'b0;
              state_nxt  = ST_SHIFT;
            end
            default: begin
              res_ok_nxt = 1'b1;
              state_nxt  = ST_FIN;
            end
          endcase
        end else if (scan_r == count_r) begin
          if (req_r == REQ_INSERT && count_r < CNT_W'(CAPACITY)) begin
            mem_we     = 1'b1;
            mem_wa     = count_r[IDX_W-1:0];
            mem_wd     = value_r;
            count_nxt  = count_r + CNT_W'(1);
            res_ok_nxt = 1'b1;
          end
          pend_nxt  = 1'b0;
          state_nxt = ST_FIN;
        end else begin
          mem_re       = 1'b1;
          mem_ra       = scan_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt     = scan_r + CNT_W'(1);
        end
      end

      ST_SHIFT: begin
        // entry read from slot k last cycle lands in slot k-1
        if (pend_r) begin
          mem_we = 1'b1;
          mem_wa = pend_idx_r - IDX_W'(1);
          mem_wd = mem_rdata;
        end
        if (scan_r < count_r) begin
          mem_re       = 1'b1;
          mem_ra       = scan_r[IDX_W-1:0];
          pend_nxt     = 1'b1;
          pend_idx_nxt = scan_r[IDX_W-1:0];
          scan_nxt     = scan_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = ST_FIN;
          end
        end
      end

      ST_RDWAIT: begin
        res_ok_nxt = 1'b1;
        res_rd_nxt = 32'(mem_rdata);
        state_nxt  = ST_FIN;
      end

      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.ok           = res_ok_r;
          out_nxt.read_value   = res_rd_r;
          out_nxt.entry_count  = 6'(count_r);
          state_nxt            = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    value_r    <= value_nxt;
    scan_r     <= scan_nxt;
    pend_idx_r <= pend_idx_nxt;
    res_ok_r   <= res_ok_nxt;
    res_rd_r   <= res_rd_nxt;
    out_r      <= out_nxt;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> (count_r == $past(count_r)) || (count_r == $past(count_r) + CNT_W'(1))
             || (count_r == $past(count_r) - CNT_W'(1)))
    else $error("entry count moved by more than one");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (CNT_W'(mem_wa) <= count_r))
    else $error("entry write beyond the held range");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

  a_idle_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> $stable(count_r))
    else $error("entry count changed with no request in flight");
`endif

endmodule

`default_nettype wire
